### rtl/msid_pkg.sv
// Package with the shared types and codes of the MIPS subset instruction decoder.
package msid_pkg;

   // Depth of the queue between the classifying front and the decoding back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Instruction field codes.
   localparam logic [5:0] OP_SPECIAL = 6'b000000;
   localparam logic [5:0] OP_REGIMM  = 6'b000001;
   localparam logic [5:0] OP_J       = 6'b000010;
   localparam logic [5:0] OP_BEQ     = 6'b000100;
   localparam logic [5:0] OP_BNE     = 6'b000101;
   localparam logic [5:0] OP_BLEZ    = 6'b000110;
   localparam logic [5:0] OP_BGTZ    = 6'b000111;
   localparam logic [5:0] OP_ADDI    = 6'b001000;
   localparam logic [5:0] OP_ADDIU   = 6'b001001;
   localparam logic [5:0] OP_SLTI    = 6'b001010;
   localparam logic [5:0] OP_LW      = 6'b100011;
   localparam logic [5:0] OP_SW      = 6'b101011;

   localparam logic [4:0] RT_BLTZ = 5'b00000;
   localparam logic [4:0] RT_BGEZ = 5'b00001;

   localparam logic [5:0] FN_SLL   = 6'b000000;
   localparam logic [5:0] FN_SRL   = 6'b000010;
   localparam logic [5:0] FN_SRA   = 6'b000011;
   localparam logic [5:0] FN_BREAK = 6'b001101;
   localparam logic [5:0] FN_ADD   = 6'b100000;
   localparam logic [5:0] FN_ADDU  = 6'b100001;
   localparam logic [5:0] FN_SUB   = 6'b100010;
   localparam logic [5:0] FN_SUBU  = 6'b100011;
   localparam logic [5:0] FN_AND   = 6'b100100;
   localparam logic [5:0] FN_OR    = 6'b100101;
   localparam logic [5:0] FN_XOR   = 6'b100110;
   localparam logic [5:0] FN_NOR   = 6'b100111;
   localparam logic [5:0] FN_SLT   = 6'b101010;
   localparam logic [5:0] FN_SLTU  = 6'b101011;

   // Upper address bits kept by a jump.
   localparam logic [31:0] JUMP_REGION_MASK = 32'hf000_0000;

   // Result kind codes.
   typedef enum logic [4:0] {
      KIND_DATA    = 5'd0,
      KIND_SW      = 5'd1,
      KIND_LW      = 5'd2,
      KIND_J       = 5'd3,
      KIND_BEQ     = 5'd4,
      KIND_BNE     = 5'd5,
      KIND_BGEZ    = 5'd6,
      KIND_BGTZ    = 5'd7,
      KIND_BLEZ    = 5'd8,
      KIND_BLTZ    = 5'd9,
      KIND_ADDI    = 5'd10,
      KIND_ADDIU   = 5'd11,
      KIND_SLTI    = 5'd12,
      KIND_BREAK   = 5'd13,
      KIND_SLL     = 5'd14,
      KIND_SRL     = 5'd15,
      KIND_SRA     = 5'd16,
      KIND_SLT     = 5'd17,
      KIND_SLTU    = 5'd18,
      KIND_SUB     = 5'd19,
      KIND_SUBU    = 5'd20,
      KIND_ADD     = 5'd21,
      KIND_ADDU    = 5'd22,
      KIND_AND     = 5'd23,
      KIND_OR      = 5'd24,
      KIND_XOR     = 5'd25,
      KIND_NOR     = 5'd26,
      KIND_NOP     = 5'd27,
      KIND_UNKNOWN = 5'd28
   } kind_type;

   // A classified word as it travels from the front to the back.
   typedef struct packed {
      logic [31:0] word_address;
      logic [31:0] word;
      kind_type    kind;
   } front_item_type;

   // A fully decoded result word.
   typedef struct packed {
      logic               dest_used;
      logic               source_b_used;
      logic               source_a_used;
      logic [4:0]         dest_reg;
      logic [4:0]         source_reg_b;
      logic [4:0]         source_reg_a;
      logic [31:0]        target_address;
      logic signed [17:0] operand_third;
      logic signed [17:0] operand_second;
      logic signed [31:0] operand_first;
      kind_type           kind;
      logic [31:0]        word_address;
   } result_type;

   localparam int RESULT_BITS = $bits(result_type);
   localparam int RSP_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

   // Register addresses of the configuration port.
   localparam logic [2:0] CSR_ADDR_BITS_START = 3'd0;

endpackage

### rtl/msid_front.sv
// Front part: keeps the word address and data mode and classifies each word.
module msid_front
   import msid_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           restart,
   input  logic [31:0]    restart_address,
   input  logic           accept,
   input  logic [31:0]    word,
   output front_item_type item
);

   logic [31:0] next_address_ff, next_address_in;
   logic        data_mode_ff, data_mode_in;
   kind_type    kind;
   logic [5:0]  op;
   logic [5:0]  fn;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [4:0]  sa;

   assign op = word[31:26];
   assign rs = word[25:21];
   assign rt = word[20:16];
   assign sa = word[10:6];
   assign fn = word[5:0];

   // Classify the word into its kind.
   always_comb begin
      kind = KIND_UNKNOWN;
      if (data_mode_ff) begin
         kind = KIND_DATA;
      end else if (word == 32'd0) begin
         kind = KIND_NOP;
      end else begin
         case (op)
            OP_SW:    kind = KIND_SW;
            OP_LW:    kind = KIND_LW;
            OP_J:     kind = KIND_J;
            OP_BEQ:   kind = KIND_BEQ;
            OP_BNE:   kind = KIND_BNE;
            OP_BGTZ:  kind = KIND_BGTZ;
            OP_BLEZ:  kind = KIND_BLEZ;
            OP_ADDI:  kind = KIND_ADDI;
            OP_ADDIU: kind = KIND_ADDIU;
            OP_SLTI:  kind = KIND_SLTI;
            OP_REGIMM: begin
               if (rt == RT_BGEZ) begin
                  kind = KIND_BGEZ;
               end else if (rt == RT_BLTZ) begin
                  kind = KIND_BLTZ;
               end
            end
            OP_SPECIAL: begin
               if (fn == FN_BREAK) begin
                  kind = KIND_BREAK;
               end else if (sa == 5'd0 && fn == FN_SLT) begin
                  kind = KIND_SLT;
               end else if (sa == 5'd0 && fn == FN_SLTU) begin
                  kind = KIND_SLTU;
               end else if (rs == 5'd0 && fn == FN_SLL) begin
                  kind = KIND_SLL;
               end else if (rs == 5'd0 && fn == FN_SRL) begin
                  kind = KIND_SRL;
               end else if (rs == 5'd0 && fn == FN_SRA) begin
                  kind = KIND_SRA;
               end else begin
                  case (fn)
                     FN_SUB:  kind = KIND_SUB;
                     FN_SUBU: kind = KIND_SUBU;
                     FN_ADD:  kind = KIND_ADD;
                     FN_ADDU: kind = KIND_ADDU;
                     FN_AND:  kind = KIND_AND;
                     FN_OR:   kind = KIND_OR;
                     FN_XOR:  kind = KIND_XOR;
                     FN_NOR:  kind = KIND_NOR;
                     default: kind = KIND_UNKNOWN;
                  endcase
               end
            end
            default: kind = KIND_UNKNOWN;
         endcase
      end
   end

   assign item.word_address = next_address_ff;
   assign item.word         = word;
   assign item.kind         = kind;

   // Address counter and data mode; a restart reloads both.
   always_comb begin
      next_address_in = next_address_ff;
      data_mode_in    = data_mode_ff;
      if (restart) begin
         next_address_in = restart_address;
         data_mode_in    = 1'b0;
      end else if (accept) begin
         next_address_in = next_address_ff + 32'd4;
         if (kind == KIND_BREAK) begin
            data_mode_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_address_ff <= 32'd0;
         data_mode_ff    <= 1'b0;
      end else begin
         next_address_ff <= next_address_in;
         data_mode_ff    <= data_mode_in;
      end
   end

endmodule

### rtl/msid_queue.sv
// Short queue of classified words between the front and the back.
module msid_queue
   import msid_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH_DEFAULT
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  front_item_type push_item,
   input  logic           pop,
   output logic           full,
   output logic           empty,
   output front_item_type head_item
);

   localparam int PtrBits   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountBits = $clog2(Depth + 1);

   front_item_type       entry_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;

   assign full      = (count_ff == CountBits'(Depth));
   assign empty     = (count_ff == '0);
   assign head_item = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/msid_back.sv
// Back part: builds operands, targets and register usage into the result register.
module msid_back
   import msid_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           head_valid,
   input  front_item_type head_item,
   output logic           pop,
   output logic           out_valid,
   input  logic           out_ready,
   output result_type     out_result
);

   result_type  result_ff, result_in;
   logic        valid_ff, valid_in;
   logic [31:0] word;
   logic [31:0] addr_plus4;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sa;
   logic signed [17:0] imm18;
   logic signed [17:0] boff18;
   logic [31:0] branch_target;
   logic [31:0] jump_target;

   assign word       = head_item.word;
   assign rs         = word[25:21];
   assign rt         = word[20:16];
   assign rd         = word[15:11];
   assign sa         = word[10:6];
   assign imm18      = {{2{word[15]}}, word[15:0]};
   assign boff18     = {word[15:0], 2'b00};
   assign addr_plus4 = head_item.word_address + 32'd4;
   assign branch_target = addr_plus4 + {{14{word[15]}}, word[15:0], 2'b00};
   assign jump_target   = (addr_plus4 & JUMP_REGION_MASK) | {4'd0, word[25:0], 2'b00};

   // Take the next word whenever the result register is free or being drained.
   assign pop = head_valid && (!valid_ff || out_ready);

   // Operand and register selection by kind.
   always_comb begin
      result_in              = '0;
      result_in.word_address = head_item.word_address;
      result_in.kind         = head_item.kind;
      case (head_item.kind)
         KIND_DATA: begin
            result_in.operand_first = word;
         end
         KIND_SW, KIND_LW: begin
            result_in.operand_first  = {27'd0, rt};
            result_in.operand_second = imm18;
            result_in.operand_third  = {13'd0, rs};
            result_in.source_a_used  = 1'b1;
            if (head_item.kind == KIND_SW) begin
               result_in.source_reg_a  = rt;
               result_in.source_reg_b  = rs;
               result_in.source_b_used = 1'b1;
            end else begin
               result_in.source_reg_a = rs;
               result_in.dest_reg     = rt;
               result_in.dest_used    = 1'b1;
            end
         end
         KIND_J: begin
            result_in.operand_first  = jump_target;
            result_in.target_address = jump_target;
         end
         KIND_BEQ, KIND_BNE: begin
            result_in.operand_first  = {27'd0, rs};
            result_in.operand_second = {13'd0, rt};
            result_in.operand_third  = boff18;
            result_in.target_address = branch_target;
            result_in.source_reg_a   = rs;
            result_in.source_reg_b   = rt;
            result_in.source_a_used  = 1'b1;
            result_in.source_b_used  = 1'b1;
         end
         KIND_BGEZ, KIND_BGTZ, KIND_BLEZ, KIND_BLTZ: begin
            result_in.operand_first  = {27'd0, rs};
            result_in.operand_second = boff18;
            result_in.target_address = branch_target;
            result_in.source_reg_a   = rs;
            result_in.source_a_used  = 1'b1;
         end
         KIND_ADDI, KIND_ADDIU, KIND_SLTI: begin
            result_in.operand_first  = {27'd0, rt};
            result_in.operand_second = {13'd0, rs};
            result_in.operand_third  = imm18;
            result_in.source_reg_a   = rs;
            result_in.source_a_used  = 1'b1;
            result_in.dest_reg       = rt;
            result_in.dest_used      = 1'b1;
         end
         KIND_SLL, KIND_SRL, KIND_SRA: begin
            result_in.operand_first  = {27'd0, rd};
            result_in.operand_second = {13'd0, rt};
            result_in.operand_third  = {13'd0, sa};
            result_in.source_reg_a   = rt;
            result_in.source_a_used  = 1'b1;
            result_in.dest_reg       = rd;
            result_in.dest_used      = 1'b1;
         end
         KIND_SLT, KIND_SLTU, KIND_SUB, KIND_SUBU, KIND_ADD, KIND_ADDU,
         KIND_AND, KIND_OR, KIND_XOR, KIND_NOR: begin
            result_in.operand_first  = {27'd0, rd};
            result_in.operand_second = {13'd0, rs};
            result_in.operand_third  = {13'd0, rt};
            result_in.source_reg_a   = rs;
            result_in.source_reg_b   = rt;
            result_in.source_a_used  = 1'b1;
            result_in.source_b_used  = 1'b1;
            result_in.dest_reg       = rd;
            result_in.dest_used      = 1'b1;
         end
         default: begin
            // Break, no-op and unrecognized words carry only address and kind.
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

### rtl/mips_subset_instruction_decoder.sv
// Top level of the MIPS subset instruction decoder: ports, register port and wiring.
//
// Usage: 32-bit words enter on the req_ stream, one per handshake, and each word
// gives exactly one decoded result word on the rsp_ stream, in order. The result
// carries the word's address, its kind code, three operand fields, the branch or
// jump target and the registers read and written with their valid bits.
// The front counts word addresses from program_start_address and classifies each
// word; after a BREAK every later word passes as data. A short queue parts it
// from the back, which forms operands and targets into the result register.
// A result is registered first in a queue entry and then in the result register
// before it is valid on the rsp_ stream.
// Throughput: one word per cycle while rsp_tready stays high (single result register).
// When the receiver stalls, the result register holds and the queue fills; req_
// tready drops only when the queue is full, and nothing is lost.
// Reset clears the queue, the result flag, the start address to 0 and the mode
// to instruction. Writing program_start_address on the csr_ port (only while
// idle) restarts the address count there and returns to instruction mode.
module mips_subset_instruction_decoder
   import msid_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
)
(
   input  logic                     clock,
   input  logic                     reset,
   // Input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [31:0]              req_tdata,   // instruction_word
   // Result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // word_address[31:0], kind[36:32], operand_first[68:37], operand_second[86:69],
   // operand_third[104:87], target_address[136:105], source_reg_a[141:137],
   // source_reg_b[146:142], dest_reg[151:147], source_a_used[152],
   // source_b_used[153], dest_used[154], zero fill above
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // Configuration port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic           start_write;
   logic [31:0]    start_address_ff;
   logic           accept;
   logic           queue_full;
   logic           queue_empty;
   logic           pop;
   front_item_type front_item;
   front_item_type head_item;
   result_type     result;

   // Register port: one register, always ready.
   assign csr_pready  = 1'b1;
   assign start_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                        && (csr_paddr[2] == CSR_ADDR_BITS_START[2]);
   assign csr_prdata  = (csr_paddr[2] == CSR_ADDR_BITS_START[2]) ? start_address_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= 32'd0;
      end else if (start_write) begin
         start_address_ff <= csr_pwdata;
      end
   end

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   msid_front u_front (
      .clock           (clock),
      .reset           (reset),
      .restart         (start_write),
      .restart_address (csr_pwdata),
      .accept          (accept),
      .word            (req_tdata),
      .item            (front_item)
   );

   msid_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   msid_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!queue_empty),
      .head_item  (head_item),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - RESULT_BITS){1'b0}}, result};

endmodule
